[sv/axis_normalize_poly_curve_unit_assert.svh]
// assertion macros shared by the curve unit modules
`ifndef AXIS_NORMALIZE_POLY_CURVE_UNIT_ASSERT_SVH
`define AXIS_NORMALIZE_POLY_CURVE_UNIT_ASSERT_SVH

// a condition implies a consequence in the same cycle
`define ANPC_ASSERT_IMPLY(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

// a condition implies a consequence in the following cycle
`define ANPC_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`endif

[sv/anpc_pkg.sv]
// ----------------------------------------------------------------------------
// anpc_pkg
// shared constants and types of the axis normalize curve unit
// ----------------------------------------------------------------------------
package anpc_pkg;

    localparam int RAW_BITS_DEF  = 16;
    localparam int MAX_TERMS_DEF = 4;
    localparam int COEF_REGS     = 4;
    localparam int COEF_W        = 24;
    localparam int X_W           = 18;
    localparam int OUT_W         = 32;
    localparam int Q_BITS        = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW    = 3'd0,
        REG_HIGH   = 3'd1,
        REG_CENTER = 3'd2,
        REG_TERMS  = 3'd3,
        REG_C0     = 3'd4,
        REG_C1     = 3'd5,
        REG_C2     = 3'd6,
        REG_C3     = 3'd7
    } cfg_reg_t;

    localparam logic signed [X_W-1:0] X_MAX = 18'sd131071;
    localparam logic signed [X_W-1:0] X_MIN = -18'sd131072;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] mx;
        logic signed [63:0] mn;
        begin
            mx = 64'sd2147483647;
            mn = -64'sd2147483648;
            if (v > mx) begin
                sat32 = mx[OUT_W-1:0];
            end else if (v < mn) begin
                sat32 = mn[OUT_W-1:0];
            end else begin
                sat32 = v[OUT_W-1:0];
            end
        end
    endfunction

endpackage

[sv/anpc_span.sv]
// ----------------------------------------------------------------------------
// anpc_span
// clamp, neutral subtraction and span selection, one register stage
// ----------------------------------------------------------------------------
module anpc_span import anpc_pkg::*; #(
    parameter int RAW_BITS = RAW_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [RAW_BITS-1:0] sample,
    input  logic signed [RAW_BITS-1:0] low_lim,
    input  logic signed [RAW_BITS-1:0] high_lim,
    input  logic signed [RAW_BITS-1:0] center,
    output logic                  out_valid,
    output logic signed [RAW_BITS+1:0] num,
    output logic [RAW_BITS+1:0]   span,
    output logic                  neg
);
    localparam int DW = RAW_BITS + 2;

    logic signed [DW-1:0] v, lo, hi, ce, dmax, dmin, dv, sp, amax, amin;
    logic valid_reg;
    logic signed [DW-1:0] dv_reg;
    logic [DW-1:0] mag_reg;
    logic neg_reg;

    always_comb begin
        lo = DW'(low_lim);
        hi = DW'(high_lim);
        ce = DW'(center);
        v  = DW'(sample);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        dmax = hi - ce;
        dmin = lo - ce;
        dv   = v - ce;
        amax = dmax[DW-1] ? -dmax : dmax;
        amin = dmin[DW-1] ? -dmin : dmin;
        if (hi == -lo || lo == ce) begin
            sp = dmax;
        end else if (hi == ce) begin
            sp = dmin;
        end else if (amax >= amin) begin
            sp = amax;
        end else begin
            sp = amin;
        end
    end

    // divide as magnitudes, sign folded back after
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            dv_reg  <= dv;
            mag_reg <= sp[DW-1] ? DW'(-sp) : DW'(sp);
            neg_reg <= sp[DW-1] ^ dv[DW-1];
        end
    end

    assign out_valid = valid_reg;
    assign num  = dv_reg[DW-1] ? -dv_reg : dv_reg;
    assign span = mag_reg;
    assign neg  = neg_reg;
endmodule

[sv/anpc_div.sv]
// ----------------------------------------------------------------------------
// anpc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module anpc_div import anpc_pkg::*; #(
    parameter int RAW_BITS = RAW_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [RAW_BITS+1:0]     num,
    input  logic [RAW_BITS+1:0]     span,
    input  logic                    neg,
    output logic                    out_valid,
    output logic signed [X_W-1:0]   x,
    output logic                    fault
);
    localparam int DW = RAW_BITS + 2;
    localparam int NW = DW + Q_BITS;

    logic          v_reg   [NW+1];
    logic [NW-1:0] n_reg   [NW+1];
    logic [NW-1:0] q_reg   [NW+1];
    logic [DW:0]   r_reg   [NW+1];
    logic [DW-1:0] d_reg   [NW+1];
    logic          s_reg   [NW+1];
    logic          valid_reg;
    logic signed [X_W-1:0] x_reg;
    logic          fault_reg;
    logic [NW:0]   sq;
    logic [NW+1:0] qs;

    always_comb begin
        v_reg[0] = in_valid;
        n_reg[0] = {num, {Q_BITS{1'b0}}};
        q_reg[0] = '0;
        r_reg[0] = '0;
        d_reg[0] = span;
        s_reg[0] = neg;
    end

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [DW+1:0] rs;
        logic [DW+1:0] df;
        assign rs = {r_reg[i], n_reg[i][NW-1-i]};
        assign df = rs - {2'b00, d_reg[i]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (en) begin
                n_reg[i+1] <= n_reg[i];
                d_reg[i+1] <= d_reg[i];
                s_reg[i+1] <= s_reg[i];
                if (!df[DW+1]) begin
                    r_reg[i+1] <= df[DW:0];
                    q_reg[i+1] <= q_reg[i] | (NW'(1) << (NW-1-i));
                end else begin
                    r_reg[i+1] <= rs[DW:0];
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end
    end

    always_comb begin
        sq = {1'b0, q_reg[NW]};
        qs = s_reg[NW] ? -{1'b0, sq} : {1'b0, sq};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= v_reg[NW];
        end
        if (en) begin
            fault_reg <= (d_reg[NW] == '0);
            if (!s_reg[NW] && sq > (NW+1)'(131071)) begin
                x_reg <= X_MAX;
            end else if (s_reg[NW] && sq > (NW+1)'(131072)) begin
                x_reg <= X_MIN;
            end else begin
                x_reg <= qs[X_W-1:0];
            end
        end
    end

    assign out_valid = valid_reg;
    assign x = x_reg;
    assign fault = fault_reg;
endmodule

[sv/anpc_horner.sv]
// ----------------------------------------------------------------------------
// anpc_horner
// horner evaluation, a multiply stage and a rescale stage per power
// ----------------------------------------------------------------------------
module anpc_horner import anpc_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [X_W-1:0]  x,
    input  logic                   fault,
    input  logic [2:0]             terms,
    input  logic signed [COEF_W-1:0] coef [COEF_REGS],
    output logic                   out_valid,
    output logic signed [OUT_W-1:0] value,
    output logic                   fault_out
);
    localparam int NS = COEF_REGS - 1;
    localparam int LIM = (MAX_TERMS < COEF_REGS) ? MAX_TERMS : COEF_REGS;

    logic [2:0] n;
    always_comb begin
        n = (terms > 3'(LIM)) ? 3'(LIM) : terms;
    end

    // acc enters at stage 0 as the top coefficient, or as x when terms is zero; stage j handles power NS-1-j
    logic                    v_reg [NS+1];
    logic signed [OUT_W-1:0] a_reg [NS+1];
    logic signed [X_W-1:0]   x_reg [NS+1];
    logic                    f_reg [NS+1];
    logic [2:0]              n_reg [NS+1];

    always_comb begin
        v_reg[0] = in_valid;
        x_reg[0] = x;
        f_reg[0] = fault;
        n_reg[0] = n;
        a_reg[0] = (n == 3'd0) ? OUT_W'(x) : OUT_W'(coef[NS]);
    end

    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam int K = NS - 1 - j;
        logic                    mv_reg;
        logic signed [OUT_W-1:0] ma_reg;
        logic signed [49:0]      p_reg;
        logic signed [X_W-1:0]   mx_reg;
        logic                    mf_reg;
        logic [2:0]              mn_reg;
        logic signed [63:0]      sum;
        logic                    mact;

        // acc is reset to c[n-1] where this power is the top one
        assign mact = (mn_reg > 3'(K + 1));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mv_reg <= 1'b0;
            end else if (en) begin
                mv_reg <= v_reg[j];
            end
            if (en) begin
                ma_reg <= (n_reg[j] == 3'(K + 1)) ? OUT_W'(coef[K]) : a_reg[j];
                p_reg  <= 50'(a_reg[j]) * 50'(x_reg[j]);
                mx_reg <= x_reg[j];
                mf_reg <= f_reg[j];
                mn_reg <= n_reg[j];
            end
        end

        always_comb begin
            sum = 64'(p_reg >>> Q_BITS) + 64'(coef[K]);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_reg[j+1] <= mv_reg;
            end
            if (en) begin
                a_reg[j+1] <= mact ? sat32(sum) : ma_reg;
                x_reg[j+1] <= mx_reg;
                f_reg[j+1] <= mf_reg;
                n_reg[j+1] <= mn_reg;
            end
        end
    end

    assign out_valid = v_reg[NS];
    assign value     = f_reg[NS] ? '0 : a_reg[NS];
    assign fault_out = f_reg[NS];
endmodule

[sv/axis_normalize_poly_curve_unit.sv]
// ----------------------------------------------------------------------------
// axis_normalize_poly_curve_unit
// joystick axis normalizer with a polynomial response curve
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output is not stalled. Each raw sample
// is clamped, centered and divided by the span in a bit-per-stage divider
// (RAW_BITS+18 stages), then runs through a Horner pipeline of two stages
// per power. The fully pipelined divider takes a new word before the last
// is through. The whole pipe moves on a single output register, so a stalled
// receiver freezes every stage without loss.
`include "axis_normalize_poly_curve_unit_assert.svh"
module axis_normalize_poly_curve_unit import anpc_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int RAW_BITS  = RAW_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample input: [RAW_BITS-1:0] raw_sample
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((RAW_BITS+7)/8)*8-1:0] s_tdata,
    // result: [31:0] mapped_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    // [0] scale_fault
    output logic                  m_tuser
);
    logic signed [RAW_BITS-1:0] low_reg, high_reg, center_reg;
    logic [2:0] terms_reg;
    logic signed [COEF_W-1:0] coef_reg [COEF_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg    <= {1'b1, {(RAW_BITS-1){1'b0}}};
            high_reg   <= {1'b0, {(RAW_BITS-1){1'b1}}};
            center_reg <= '0;
            terms_reg  <= '0;
            coef_reg[0] <= '0;
            coef_reg[1] <= COEF_W'(65536);
            coef_reg[2] <= '0;
            coef_reg[3] <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOW:    low_reg    <= cfg_data[RAW_BITS-1:0];
                REG_HIGH:   high_reg   <= cfg_data[RAW_BITS-1:0];
                REG_CENTER: center_reg <= cfg_data[RAW_BITS-1:0];
                REG_TERMS:  terms_reg  <= cfg_data[2:0];
                REG_C0:     coef_reg[0] <= cfg_data[COEF_W-1:0];
                REG_C1:     coef_reg[1] <= cfg_data[COEF_W-1:0];
                REG_C2:     coef_reg[2] <= cfg_data[COEF_W-1:0];
                REG_C3:     coef_reg[3] <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // pipe advances whenever the output register is free or being drained
    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    logic sp_valid, sp_neg, dv_valid, dv_fault, hn_valid, hn_fault;
    logic [RAW_BITS+1:0] sp_num, sp_span;
    logic signed [X_W-1:0] dv_x;
    logic signed [OUT_W-1:0] hn_value;

    anpc_span #(.RAW_BITS(RAW_BITS)) u_span (
        .aclk, .aresetn, .en,
        .in_valid(s_tvalid), .sample(s_tdata[RAW_BITS-1:0]),
        .low_lim(low_reg), .high_lim(high_reg), .center(center_reg),
        .out_valid(sp_valid), .num(sp_num), .span(sp_span), .neg(sp_neg)
    );

    anpc_div #(.RAW_BITS(RAW_BITS)) u_div (
        .aclk, .aresetn, .en,
        .in_valid(sp_valid), .num(sp_num), .span(sp_span), .neg(sp_neg),
        .out_valid(dv_valid), .x(dv_x), .fault(dv_fault)
    );

    anpc_horner #(.MAX_TERMS(MAX_TERMS)) u_horner (
        .aclk, .aresetn, .en,
        .in_valid(dv_valid), .x(dv_x), .fault(dv_fault),
        .terms(terms_reg), .coef(coef_reg),
        .out_valid(hn_valid), .value(hn_value), .fault_out(hn_fault)
    );

    // output register
    logic valid_reg, fault_reg;
    logic [OUT_W-1:0] data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= hn_valid;
        end
        if (en) begin
            data_reg  <= hn_value;
            fault_reg <= hn_fault;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = fault_reg;

    `ANPC_ASSERT_IMPLY(a_fault_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0, "fault word must carry zero")
    `ANPC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `ANPC_ASSERT_IMPLY(a_ready, aclk, aresetn, !m_tvalid, s_tready, "input blocked with empty output")
endmodule
